// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define WSN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define WSN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define WSN_ASSERT(label, prop, msg)
`define WSN_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/wsn_pkg.sv =====
package wsn_pkg;

    localparam int STR_W  = 32;
    localparam int INC_W  = 25;
    localparam int PER_W  = 16;
    localparam int CNT_W  = 17;
    localparam int IDX_W  = 7;
    localparam int FRAC_W = 24;
    localparam int QUO_W  = FRAC_W + 1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 1'b1;

    localparam logic [INC_W-1:0] INC_RESET    = 25'd167772;
    localparam logic [PER_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [QUO_W-1:0] ONE_Q24      = 25'h1000000;

    typedef logic [STR_W-1:0] t_strength;

    typedef struct packed {
        logic      start;
        t_strength dividend;
    } t_div_req;

endpackage

// ===== hdl/wsn_req_if.sv =====
interface wsn_req_if import wsn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [IDX_W-1:0] unit_index;
    t_strength        load_value;

    modport source (output valid, kind, unit_index, load_value, input ready);
    modport sink   (input valid, kind, unit_index, load_value, output ready);
endinterface

// ===== hdl/wsn_rsp_if.sv =====
interface wsn_rsp_if import wsn_pkg::*; ();
    logic      valid;
    logic      ready;
    t_strength unit_strength;
    logic      normalized;
    logic      bad_index;

    modport source (output valid, unit_strength, normalized, bad_index, input ready);
    modport sink   (input valid, unit_strength, normalized, bad_index, output ready);
endinterface

// ===== hdl/winner_strength_normalizer.sv =====
// Hit: read, bit-serial add and write back before the result; a load or bad index goes straight to the result.
// A hit whose step count exceeds the period then sums the table, and when the
// sum exceeds 1.0 divides every entry by it (bit-serial divide per entry).
// One request at a time; the next request is taken while a result waits in the output register.
// Reset (synchronous, active low) restores the control registers, then a clearing pass
// zeroes the table while no request is taken; configuration writes are accepted throughout.
`include "assert_macros.svh"

module winner_strength_normalizer import wsn_pkg::*; #(
    parameter int UNITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wsn_req_if.sink              i_req,
    wsn_rsp_if.source            o_rsp,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [INC_W-1:0]     i_cfg_data
);

    localparam int AW    = $clog2(UNITS);
    localparam int SUM_W = STR_W + AW;
    localparam int CMP_W = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam logic [AW:0] LAST_ADDR = (AW+1)'(UNITS - 1);
    localparam logic [AW:0] END_ADDR  = (AW+1)'(UNITS);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_H_LD  = 4'd2;
    localparam logic [3:0] ST_H_ADD = 4'd3;
    localparam logic [3:0] ST_H_WR  = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_CHK   = 4'd6;
    localparam logic [3:0] ST_N_RD  = 4'd7;
    localparam logic [3:0] ST_N_LD  = 4'd8;
    localparam logic [3:0] ST_N_DIV = 4'd9;
    localparam logic [3:0] ST_N_WR  = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0]       r_state, n_state;
    logic [AW:0]      r_addr, n_addr;
    logic [AW-1:0]    r_idx, n_idx;
    t_strength        r_strength, n_strength;
    logic             r_norm, n_norm;
    logic             r_bad, n_bad;
    logic [CNT_W-1:0] r_count, n_count;
    logic [INC_W-1:0] r_inc, n_inc;
    logic [PER_W-1:0] r_period, n_period;
    logic [SUM_W-1:0] r_total, n_total;
    logic             r_out_vld, n_out_vld;
    t_strength        r_out_str, n_out_str;
    logic             r_out_norm, n_out_norm;
    logic             r_out_bad, n_out_bad;

    logic             w_accept;
    logic [CMP_W-1:0] w_idx_ext;
    logic             w_idx_ok;
    logic             w_period_hit;

    logic             w_ram_we;
    logic             w_ram_re;
    logic [AW-1:0]    w_ram_addr;
    t_strength        w_ram_wdata;
    t_strength        w_ram_rdata;

    logic             w_add_start;
    logic             w_add_done;
    t_strength        w_add_sum;

    t_div_req         w_div_req;
    logic             w_div_done;
    logic [QUO_W-1:0] w_div_quot;
    t_strength        w_quot_ext;

    assign i_req.ready  = (r_state == ST_IDLE);
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_idx_ext    = {{(CMP_W - IDX_W){1'b0}}, i_req.unit_index};
    assign w_idx_ok     = (w_idx_ext < CMP_W'(UNITS));
    assign w_period_hit = (r_count > {{(CNT_W - PER_W){1'b0}}, r_period});
    assign w_quot_ext   = {{(STR_W - QUO_W){1'b0}}, w_div_quot};

    assign w_add_start        = (r_state == ST_H_LD);
    assign w_div_req.start    = (r_state == ST_N_LD);
    assign w_div_req.dividend = w_ram_rdata;

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_addr  = r_addr[AW-1:0];
        w_ram_wdata = '0;
        unique case (r_state)
            ST_CLR: begin
                w_ram_we = 1'b1;
            end
            ST_IDLE: begin
                w_ram_addr  = w_idx_ext[AW-1:0];
                w_ram_wdata = i_req.load_value;
                w_ram_we    = w_accept && w_idx_ok && i_req.kind;
                w_ram_re    = w_accept && w_idx_ok && !i_req.kind;
            end
            ST_H_WR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_idx;
                w_ram_wdata = w_add_sum;
            end
            ST_SUM: begin
                w_ram_re = (r_addr != END_ADDR);
            end
            ST_N_RD: begin
                w_ram_re = 1'b1;
            end
            ST_N_WR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = w_quot_ext;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_strength = r_strength;
        n_norm     = r_norm;
        n_bad      = r_bad;
        n_count    = r_count;
        n_inc      = r_inc;
        n_period   = r_period;
        n_total    = r_total;
        n_out_vld  = r_out_vld;
        n_out_str  = r_out_str;
        n_out_norm = r_out_norm;
        n_out_bad  = r_out_bad;

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_INCREMENT: n_inc    = i_cfg_data;
                CFG_PERIOD:    n_period = i_cfg_data[PER_W-1:0];
            endcase
        end

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_CLR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx  = w_idx_ext[AW-1:0];
                    n_norm = 1'b0;
                    n_bad  = 1'b0;
                    if (!w_idx_ok) begin
                        n_bad      = 1'b1;
                        n_strength = '0;
                        n_state    = ST_DONE;
                    end else if (i_req.kind) begin
                        n_strength = i_req.load_value;
                        n_state    = ST_DONE;
                    end else begin
                        n_state = ST_H_LD;
                    end
                end
            end
            ST_H_LD: begin
                n_state = ST_H_ADD;
            end
            ST_H_ADD: begin
                if (w_add_done) begin
                    n_state = ST_H_WR;
                end
            end
            ST_H_WR: begin
                n_strength = w_add_sum;
                if (w_period_hit) begin
                    n_count = CNT_W'(1);
                    n_addr  = '0;
                    n_total = '0;
                    n_state = ST_SUM;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_SUM: begin
                // read data is registered, so it belongs to the previous address
                if (r_addr != '0) begin
                    n_total = r_total + {{AW{1'b0}}, w_ram_rdata};
                end
                if (r_addr == END_ADDR) begin
                    n_state = ST_CHK;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_CHK: begin
                if (r_total > SUM_W'(ONE_Q24)) begin
                    n_norm  = 1'b1;
                    n_addr  = '0;
                    n_state = ST_N_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_N_RD: begin
                n_state = ST_N_LD;
            end
            ST_N_LD: begin
                n_state = ST_N_DIV;
            end
            ST_N_DIV: begin
                if (w_div_done) begin
                    n_state = ST_N_WR;
                end
            end
            ST_N_WR: begin
                if (r_addr[AW-1:0] == r_idx) begin
                    n_strength = w_quot_ext;
                end
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DONE;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = ST_N_RD;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_str  = r_strength;
                    n_out_norm = r_norm;
                    n_out_bad  = r_bad;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_addr    <= '0;
            r_count   <= '0;
            r_inc     <= INC_RESET;
            r_period  <= PERIOD_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_count   <= n_count;
            r_inc     <= n_inc;
            r_period  <= n_period;
            r_out_vld <= n_out_vld;
        end
        r_idx      <= n_idx;
        r_strength <= n_strength;
        r_norm     <= n_norm;
        r_bad      <= n_bad;
        r_total    <= n_total;
        r_out_str  <= n_out_str;
        r_out_norm <= n_out_norm;
        r_out_bad  <= n_out_bad;
    end

    wsn_ram #(
        .WIDTH (STR_W),
        .DEPTH (UNITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    wsn_serial_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_add_start),
        .i_a     (w_ram_rdata),
        .i_b     (r_inc),
        .o_done  (w_add_done),
        .o_sum   (w_add_sum)
    );

    wsn_serial_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_divisor (r_total),
        .o_done    (w_div_done),
        .o_quot    (w_div_quot)
    );

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.unit_strength = r_out_str;
    assign o_rsp.normalized    = r_out_norm;
    assign o_rsp.bad_index     = r_out_bad;

    `WSN_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> (r_state == ST_CLR && !r_out_vld), "reset did not start clearing")
    `WSN_ASSERT(a_bad_result, (r_out_vld && r_out_bad) |-> (r_out_str == '0 && !r_out_norm), "bad index result not empty")
    `WSN_ASSERT(a_norm_sum, (r_state == ST_DONE && r_norm) |-> (r_total > SUM_W'(ONE_Q24)), "sum not above 1.0")
    `WSN_ASSERT(a_count_restart, (r_state == ST_H_WR && w_period_hit) |=> (r_count == CNT_W'(1)), "step count did not restart")

endmodule

// ===== hdl/wsn_ram.sv =====
module wsn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/wsn_serial_add.sv =====
module wsn_serial_add import wsn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_strength        i_a,
    input  logic [INC_W-1:0] i_b,
    output logic             o_done,
    output t_strength        o_sum
);

    localparam int BC_W = $clog2(STR_W);

    t_strength        r_a, n_a;
    logic [INC_W-1:0] r_b, n_b;
    logic             r_c, n_c;
    logic [BC_W-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             w_s;

    assign w_s = r_a[0] ^ r_b[0] ^ r_c;

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_c    = r_c;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_a    = i_a;
            n_b    = i_b;
            n_c    = 1'b0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // one bit per cycle, LSB first
            n_a   = {w_s, r_a[STR_W-1:1]};
            n_b   = {1'b0, r_b[INC_W-1:1]};
            n_c   = (r_a[0] & r_b[0]) | (r_a[0] & r_c) | (r_b[0] & r_c);
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == BC_W'(STR_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
    end

    assign o_done = r_done;
    assign o_sum  = r_c ? '1 : r_a;

endmodule

// ===== hdl/wsn_serial_div.sv =====
`include "assert_macros.svh"

module wsn_serial_div import wsn_pkg::*; #(
    parameter int SUM_W = 38
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [SUM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quot
);

    localparam int QC_W = $clog2(QUO_W);

    logic [SUM_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_dbits, n_dbits;
    logic [QUO_W-1:0] r_quot, n_quot;
    logic [QC_W-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [SUM_W:0]   w_trial;
    logic [SUM_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_dbits[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = !w_diff[SUM_W];

    always_comb begin
        n_rem   = r_rem;
        n_dbits = r_dbits;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            // quotient fits in QUO_W bits, so start with the top dividend bits in place
            n_rem   = {{(SUM_W - STR_W + 1){1'b0}}, i_req.dividend[STR_W-1:1]};
            n_dbits = {i_req.dividend[0], {FRAC_W{1'b0}}};
            n_quot  = '0;
            n_cnt   = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_rem   = w_ge ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
            n_quot  = {r_quot[QUO_W-2:0], w_ge};
            n_dbits = {r_dbits[QUO_W-2:0], 1'b0};
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == QC_W'(QUO_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem   <= n_rem;
        r_dbits <= n_dbits;
        r_quot  <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `WSN_ASSERT(a_quot_bound, r_done |-> (r_quot <= ONE_Q24), "quotient above 1.0")

endmodule
